// File: rtl/xenc_pkg.sv
// ----------------------------------------------------------------------------
// xenc_pkg: shared types and constants of the instruction encoder
// Operation codes, operand sizes, opcode bytes, the queue entry that
// carries a classified instruction and the emitter's phase encoding.
// ----------------------------------------------------------------------------
package xenc_pkg;

   typedef enum logic [3:0] {
      OP_MOVRR    = 4'd0,
      OP_STORE    = 4'd1,
      OP_LOAD     = 4'd2,
      OP_MOVIMM64 = 4'd3,
      OP_LEARIP   = 4'd4,
      OP_LEABASE  = 4'd5,
      OP_PUSH     = 4'd6,
      OP_POP      = 4'd7,
      OP_ADDIMM   = 4'd8,
      OP_SUBIMM   = 4'd9,
      OP_ADDRR    = 4'd10,
      OP_SUBRR    = 4'd11
   } op_type;

   typedef enum logic [1:0] {
      SIZE_1 = 2'd0,
      SIZE_2 = 2'd1,
      SIZE_4 = 2'd2,
      SIZE_8 = 2'd3
   } size_type;

   // Prefix and opcode bytes
   localparam logic [7:0] OSIZE_PREFIX   = 8'h66;
   localparam logic [7:0] REX_BASE       = 8'h40;
   localparam logic [7:0] SIB_BASE_ONLY  = 8'h24;
   localparam logic [7:0] OPC_MOVB_STORE = 8'h88;
   localparam logic [7:0] OPC_MOV_STORE  = 8'h89;
   localparam logic [7:0] OPC_LOAD_ADJ   = 8'h02;
   localparam logic [7:0] OPC_MOV_LOAD   = 8'h8B;
   localparam logic [7:0] OPC_LEA        = 8'h8D;
   localparam logic [7:0] OPC_MOV_IMM    = 8'hB8;
   localparam logic [7:0] OPC_PUSH       = 8'h50;
   localparam logic [7:0] OPC_POP        = 8'h58;
   localparam logic [7:0] OPC_GRP1_IMM8  = 8'h80;
   localparam logic [7:0] OPC_GRP1_IMM32 = 8'h81;
   localparam logic [7:0] OPC_ADDB       = 8'h00;
   localparam logic [7:0] OPC_ADD        = 8'h01;
   localparam logic [7:0] OPC_SUBB       = 8'h28;
   localparam logic [7:0] OPC_SUB        = 8'h29;

   // ModRM fields
   localparam logic [1:0] MOD_INDIRECT = 2'd0;
   localparam logic [1:0] MOD_DISP32   = 2'd2;
   localparam logic [1:0] MOD_REG      = 2'd3;
   localparam logic [2:0] RM_RIP       = 3'd5;
   localparam logic [2:0] RM_SIB       = 3'd4;
   localparam logic [2:0] EXT_ADD      = 3'd0;
   localparam logic [2:0] EXT_SUB      = 3'd5;

   // Trailing field lengths in bytes
   localparam logic [3:0] TAIL_NONE = 4'd0;
   localparam logic [3:0] TAIL_IMM8 = 4'd1;
   localparam logic [3:0] TAIL_D32  = 4'd4;
   localparam logic [3:0] TAIL_I64  = 4'd8;

   // Queue between classifier and emitter
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One classified instruction
   typedef struct packed {
      logic       osize_en;
      logic       rex_en;
      logic [7:0] rex;
      logic [7:0] opc;
      logic       modrm_en;
      logic [7:0] modrm;
      logic       sib_en;
      logic [63:0] tail;
      logic [3:0] tail_len;
   } entry_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_OSIZE = 3'd1,
      PH_REX   = 3'd2,
      PH_OPC   = 3'd3,
      PH_MODRM = 3'd4,
      PH_SIB   = 3'd5,
      PH_TAIL  = 3'd6
   } phase_type;

   function automatic logic [7:0] rex_of(input logic w, input logic r, input logic b);
      rex_of = REX_BASE | {4'b0000, w, r, 1'b0, b};
   endfunction

endpackage

// File: rtl/x86_64_instruction_encoder.sv
// ----------------------------------------------------------------------------
// x86_64_instruction_encoder: x86-64 machine code emitter
// Encodes one instruction request into its byte sequence with a final-byte
// mark, through a classifier, a two-entry queue and a byte emitter.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_* and raise start; the transaction is taken
//   at a rising edge where start is high and busy is low. busy is high only
//   while the queue holds two instructions not yet started by the emitter.
//   Result channel: rsp_strobe marks a byte on rsp_code_byte for exactly one
//   cycle, rsp_last_byte flags the final byte of an instruction. The
//   receiver cannot stall, so bytes flow at one per cycle without gaps
//   between instructions while work is queued.
//   Order: an accepted transaction is written into the queue and, once the
//   emitter is idle or on its final byte, loaded into the emitter's
//   registers, which drive its first byte onto the result ports.
//   Throughput: instructions are 2 to 10 bytes long (push, pop and
//   byte-size register add and sub the shortest, mov imm64 the longest);
//   the emitter's one-byte-a-cycle output sets the rate. Requests are taken
//   one per cycle while the queue has room.
//   Unknown operations are taken and dropped; they produce no bytes.
//   Reset empties the queue and idles the emitter; nothing is emitted until
//   a new transaction arrives.
// ----------------------------------------------------------------------------
module x86_64_instruction_encoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [3:0]         req_operation,
   input  logic [3:0]         req_reg_a,
   input  logic [3:0]         req_reg_b,
   input  logic [1:0]         req_size_code,
   input  logic signed [31:0] req_displacement,
   input  logic [63:0]        req_immediate,
   output logic               rsp_strobe,
   output logic [7:0]         rsp_code_byte,
   output logic               rsp_last_byte
);

   xenc_pkg::entry_type front_entry;
   xenc_pkg::entry_type head_entry;
   logic                known;
   logic                q_push, q_pop, q_empty, q_full;

   // Classify the request in the cycle it is offered
   xenc_front u_front (
      .req_operation    (req_operation),
      .req_reg_a        (req_reg_a),
      .req_reg_b        (req_reg_b),
      .req_size_code    (req_size_code),
      .req_displacement (req_displacement),
      .req_immediate    (req_immediate),
      .entry            (front_entry),
      .known            (known)
   );

   // Hold the request off only when the queue is full
   assign busy   = q_full;
   // Drop unknown operations at the door
   assign q_push = start && !busy && known;

   xenc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (front_entry),
      .pop        (q_pop),
      .head       (head_entry),
      .empty      (q_empty),
      .full       (q_full)
   );

   // Emit one byte a cycle, fetch the next instruction on the last byte
   xenc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head_entry),
      .empty         (q_empty),
      .pop           (q_pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_code_byte (rsp_code_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

// File: rtl/xenc_front.sv
// ----------------------------------------------------------------------------
// xenc_front: instruction classifier
// Turns one request into prefix flags, REX, opcode, ModRM, SIB flag and a
// little-endian trailing field; flags unknown operations.
// ----------------------------------------------------------------------------
module xenc_front (
   input  logic [3:0]          req_operation,
   input  logic [3:0]          req_reg_a,
   input  logic [3:0]          req_reg_b,
   input  logic [1:0]          req_size_code,
   input  logic signed [31:0]  req_displacement,
   input  logic [63:0]         req_immediate,
   output xenc_pkg::entry_type entry,
   output logic                known
);

   // Prefixes, opcode and ModRM of the general register/memory form
   function automatic xenc_pkg::entry_type modrm_form(
      input logic [7:0] opc,
      input logic [1:0] md,
      input logic [3:0] regf,
      input logic [3:0] rm,
      input logic [1:0] size
   );
      xenc_pkg::entry_type e;
      e          = '0;
      e.osize_en = (size == xenc_pkg::SIZE_2);
      e.rex_en   = (size != xenc_pkg::SIZE_1) || regf[3] || regf[2] || rm[3]
                   || ((md == xenc_pkg::MOD_REG) && rm[2]);
      e.rex      = xenc_pkg::rex_of(size == xenc_pkg::SIZE_8, regf[3], rm[3]);
      e.opc      = opc;
      e.modrm_en = 1'b1;
      e.modrm    = {md, regf[2:0], rm[2:0]};
      e.sib_en   = (md != xenc_pkg::MOD_REG) && (rm[2:0] == xenc_pkg::RM_SIB);
      e.tail_len = xenc_pkg::TAIL_NONE;
      return e;
   endfunction

   always_comb begin
      logic [7:0] opc;
      logic [1:0] psize;
      logic [2:0] ext;
      entry = '0;
      known = 1'b1;
      opc   = '0;
      psize = req_size_code;
      ext   = xenc_pkg::EXT_ADD;
      case (xenc_pkg::op_type'(req_operation))
         xenc_pkg::OP_MOVRR: begin
            entry = modrm_form(xenc_pkg::OPC_MOV_LOAD, xenc_pkg::MOD_REG,
                               req_reg_a, req_reg_b, xenc_pkg::SIZE_8);
         end
         xenc_pkg::OP_STORE, xenc_pkg::OP_LOAD: begin
            opc = (req_size_code == xenc_pkg::SIZE_1) ? xenc_pkg::OPC_MOVB_STORE
                                                       : xenc_pkg::OPC_MOV_STORE;
            if (req_operation == xenc_pkg::OP_LOAD) begin
               opc = opc + xenc_pkg::OPC_LOAD_ADJ;
            end
            entry = modrm_form(opc, xenc_pkg::MOD_DISP32, req_reg_a, req_reg_b,
                               req_size_code);
            entry.tail     = {32'd0, req_displacement};
            entry.tail_len = xenc_pkg::TAIL_D32;
         end
         xenc_pkg::OP_MOVIMM64: begin
            entry.rex_en   = 1'b1;
            entry.rex      = xenc_pkg::rex_of(1'b1, 1'b0, req_reg_a[3]);
            entry.opc      = xenc_pkg::OPC_MOV_IMM | {5'd0, req_reg_a[2:0]};
            entry.tail     = req_immediate;
            entry.tail_len = xenc_pkg::TAIL_I64;
         end
         xenc_pkg::OP_LEARIP: begin
            entry.rex_en   = 1'b1;
            entry.rex      = xenc_pkg::rex_of(1'b1, req_reg_a[3], 1'b0);
            entry.opc      = xenc_pkg::OPC_LEA;
            entry.modrm_en = 1'b1;
            entry.modrm    = {xenc_pkg::MOD_INDIRECT, req_reg_a[2:0], xenc_pkg::RM_RIP};
            entry.tail     = {32'd0, req_displacement};
            entry.tail_len = xenc_pkg::TAIL_D32;
         end
         xenc_pkg::OP_LEABASE: begin
            entry = modrm_form(xenc_pkg::OPC_LEA, xenc_pkg::MOD_DISP32,
                               req_reg_a, req_reg_b, xenc_pkg::SIZE_8);
            entry.tail     = {32'd0, req_displacement};
            entry.tail_len = xenc_pkg::TAIL_D32;
         end
         xenc_pkg::OP_PUSH, xenc_pkg::OP_POP: begin
            // byte size runs as 4 bytes
            if (req_size_code == xenc_pkg::SIZE_1) begin
               psize = xenc_pkg::SIZE_4;
            end
            opc = (req_operation == xenc_pkg::OP_POP) ? xenc_pkg::OPC_POP
                                                       : xenc_pkg::OPC_PUSH;
            entry.osize_en = (psize == xenc_pkg::SIZE_2);
            entry.rex_en   = 1'b1;
            entry.rex      = xenc_pkg::rex_of(psize == xenc_pkg::SIZE_8, 1'b0,
                                              req_reg_a[3]);
            entry.opc      = opc | {5'd0, req_reg_a[2:0]};
         end
         xenc_pkg::OP_ADDIMM, xenc_pkg::OP_SUBIMM: begin
            ext = (req_operation == xenc_pkg::OP_SUBIMM) ? xenc_pkg::EXT_SUB
                                                          : xenc_pkg::EXT_ADD;
            entry.rex_en   = 1'b1;
            entry.rex      = xenc_pkg::rex_of(1'b1, 1'b0, req_reg_a[3]);
            entry.modrm_en = 1'b1;
            entry.modrm    = {xenc_pkg::MOD_REG, ext, req_reg_a[2:0]};
            entry.tail     = req_immediate;
            if (req_size_code == xenc_pkg::SIZE_1) begin
               entry.opc      = xenc_pkg::OPC_GRP1_IMM8;
               entry.tail_len = xenc_pkg::TAIL_IMM8;
            end else begin
               entry.opc      = xenc_pkg::OPC_GRP1_IMM32;
               entry.tail_len = xenc_pkg::TAIL_D32;
            end
         end
         xenc_pkg::OP_ADDRR: begin
            opc = (req_size_code == xenc_pkg::SIZE_1) ? xenc_pkg::OPC_ADDB
                                                       : xenc_pkg::OPC_ADD;
            entry = modrm_form(opc, xenc_pkg::MOD_REG, req_reg_b, req_reg_a,
                               req_size_code);
         end
         xenc_pkg::OP_SUBRR: begin
            opc = (req_size_code == xenc_pkg::SIZE_1) ? xenc_pkg::OPC_SUBB
                                                       : xenc_pkg::OPC_SUB;
            entry = modrm_form(opc, xenc_pkg::MOD_REG, req_reg_b, req_reg_a,
                               req_size_code);
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

endmodule

// File: rtl/xenc_queue.sv
// ----------------------------------------------------------------------------
// xenc_queue: short instruction queue
// Holds classified instructions between classifier and emitter.
// ----------------------------------------------------------------------------
module xenc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  xenc_pkg::entry_type push_entry,
   input  logic                pop,
   output xenc_pkg::entry_type head,
   output logic                empty,
   output logic                full
);

   xenc_pkg::entry_type                 slot_ff [xenc_pkg::QUEUE_DEPTH];
   logic [xenc_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [xenc_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [xenc_pkg::QCNT_W-1:0]         count_ff, count_in;

   function automatic logic [xenc_pkg::QPTR_W-1:0] ptr_next(
      input logic [xenc_pkg::QPTR_W-1:0] p
   );
      if (p == xenc_pkg::QPTR_W'(xenc_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign empty = (count_ff == '0);
   assign full  = (count_ff == xenc_pkg::QCNT_W'(xenc_pkg::QUEUE_DEPTH));
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= xenc_pkg::QCNT_W'(xenc_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule

// File: rtl/xenc_back.sv
// ----------------------------------------------------------------------------
// xenc_back: byte emitter
// Walks one classified instruction through its phases, one byte a cycle,
// and fetches the next one from the queue on the final byte or while idle.
// ----------------------------------------------------------------------------
module xenc_back (
   input  logic                clock,
   input  logic                reset,
   input  xenc_pkg::entry_type head,
   input  logic                empty,
   output logic                pop,
   output logic                rsp_strobe,
   output logic [7:0]          rsp_code_byte,
   output logic                rsp_last_byte
);

   xenc_pkg::phase_type phase_ff, phase_in, step_next, first_phase;
   xenc_pkg::entry_type cur_ff, cur_in;
   logic [63:0]         tail_ff, tail_in;
   logic [3:0]          tail_cnt_ff, tail_cnt_in;
   xenc_pkg::phase_type tail_phase;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= xenc_pkg::PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      tail_ff     <= tail_in;
      tail_cnt_ff <= tail_cnt_in;
   end

   always_comb begin
      tail_phase = (cur_ff.tail_len != xenc_pkg::TAIL_NONE) ? xenc_pkg::PH_TAIL
                                                              : xenc_pkg::PH_IDLE;
      case (phase_ff)
         xenc_pkg::PH_OSIZE: step_next = cur_ff.rex_en ? xenc_pkg::PH_REX
                                                       : xenc_pkg::PH_OPC;
         xenc_pkg::PH_REX:   step_next = xenc_pkg::PH_OPC;
         xenc_pkg::PH_OPC:   step_next = cur_ff.modrm_en ? xenc_pkg::PH_MODRM
                                                         : tail_phase;
         xenc_pkg::PH_MODRM: step_next = cur_ff.sib_en ? xenc_pkg::PH_SIB : tail_phase;
         xenc_pkg::PH_SIB:   step_next = tail_phase;
         xenc_pkg::PH_TAIL:  step_next = (tail_cnt_ff == 4'd1) ? xenc_pkg::PH_IDLE
                                                               : xenc_pkg::PH_TAIL;
         default:            step_next = xenc_pkg::PH_IDLE;
      endcase

      if (head.osize_en) begin
         first_phase = xenc_pkg::PH_OSIZE;
      end else if (head.rex_en) begin
         first_phase = xenc_pkg::PH_REX;
      end else begin
         first_phase = xenc_pkg::PH_OPC;
      end

      rsp_strobe    = (phase_ff != xenc_pkg::PH_IDLE);
      rsp_last_byte = rsp_strobe && (step_next == xenc_pkg::PH_IDLE);
      case (phase_ff)
         xenc_pkg::PH_OSIZE: rsp_code_byte = xenc_pkg::OSIZE_PREFIX;
         xenc_pkg::PH_REX:   rsp_code_byte = cur_ff.rex;
         xenc_pkg::PH_OPC:   rsp_code_byte = cur_ff.opc;
         xenc_pkg::PH_MODRM: rsp_code_byte = cur_ff.modrm;
         xenc_pkg::PH_SIB:   rsp_code_byte = xenc_pkg::SIB_BASE_ONLY;
         xenc_pkg::PH_TAIL:  rsp_code_byte = tail_ff[7:0];
         default:            rsp_code_byte = 8'h00;
      endcase

      // advance within the instruction; on its end take the next one
      pop         = (step_next == xenc_pkg::PH_IDLE) && !empty;
      phase_in    = step_next;
      cur_in      = cur_ff;
      tail_in     = tail_ff;
      tail_cnt_in = tail_cnt_ff;
      if (phase_ff == xenc_pkg::PH_TAIL) begin
         tail_in     = {8'h00, tail_ff[63:8]};
         tail_cnt_in = tail_cnt_ff - 4'd1;
      end
      if (pop) begin
         phase_in    = first_phase;
         cur_in      = head;
         tail_in     = head.tail;
         tail_cnt_in = head.tail_len;
      end
   end

   a_tail_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == xenc_pkg::PH_TAIL) |-> (tail_cnt_ff != 4'd0))
      else $error("tail phase with no bytes left");

   a_pop_at_end: assert property (@(posedge clock) disable iff (reset)
      pop |-> (!rsp_strobe || rsp_last_byte))
      else $error("next instruction fetched before the last byte");

   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_strobe)
      else $error("fetched instruction did not start emitting");

endmodule
